FILE: rtl/wmf_pkg.sv
package wmf_pkg;

  // Filter geometry and sample format
  localparam int unsigned WIN         = 3;
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned WSQ         = WIN * WIN;
  localparam int unsigned RANK        = WSQ / 2;
  localparam int unsigned LINES       = WIN - 1;
  // Offset from the newest sample position back to the window centre
  localparam int unsigned LAG         = WIN - 1 - WIN / 2;

  // Counter and register widths
  localparam int unsigned COL_BITS      = $clog2(MAX_COLS);
  localparam int unsigned FILL_BITS     = $clog2(MAX_COLS + 1);
  localparam int unsigned ROW_BITS      = 16;
  localparam int unsigned COLS_REG_BITS = 11;
  localparam int unsigned ROWS_REG_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned RANK_CNT_BITS = $clog2(WSQ + 1);

  // Result queue
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Occupancy of the two registered stages of the rank selector
  localparam int unsigned RS_OCC_BITS = 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_COLS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_ROWS = CFG_IDX_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WSQ-1:0] window_t;
  typedef sample_t [LINES-1:0] column_t;

  typedef struct packed {
    sample_t sample;
    logic    frame_start;
  } in_item_t;

  typedef struct packed {
    sample_t             median;
    logic [ROW_BITS-1:0] out_row;
    logic [COL_BITS-1:0] out_col;
  } out_item_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] out_row;
    logic [COL_BITS-1:0] out_col;
  } pos_t;

endpackage

FILE: rtl/wmf_line_store.sv
module wmf_line_store import wmf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [COL_BITS-1:0] rd_addr_i,
  input  logic                wr_en_i,
  input  logic [COL_BITS-1:0] wr_addr_i,
  input  column_t             wr_data_i,
  output column_t             rd_data_o
);

  // One word per column holds that column of every stored line
  column_t mem_q [MAX_COLS];
  column_t rd_word_q;
  column_t fwd_data_q;

  logic                 fwd_q;
  logic                 hit_q;
  logic [FILL_BITS-1:0] fill_q;
  logic [FILL_BITS-1:0] fill_d;

  // Synchronous memory with registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // Columns are always written in ascending order from zero, so the written
  // entries form a prefix and a fill count tells which still hold zero.
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && ({1'b0, wr_addr_i} == fill_q)) begin
      fill_d = fill_q + FILL_BITS'(1);
    end
  end

  // A read of the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      fwd_q  <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
        hit_q <= {1'b0, rd_addr_i} < fill_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (hit_q ? rd_word_q : '0);

endmodule

FILE: rtl/wmf_rank_select.sv
module wmf_rank_select import wmf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  window_t                win_i,
  input  pos_t                   pos_i,
  output logic                   out_valid_o,
  output out_item_t              out_item_o,
  output logic [RS_OCC_BITS-1:0] occupancy_o
);

  logic [WSQ-1:0] lt_d [WSQ];
  logic [WSQ-1:0] eq_d [WSQ];
  logic [WSQ-1:0] lt_q [WSQ];
  logic [WSQ-1:0] eq_q [WSQ];
  window_t        win_a_q;
  pos_t           pos_a_q;
  logic           va_q;

  logic [WSQ-1:0] hit_d;
  logic [WSQ-1:0] hit_q;
  window_t        win_b_q;
  pos_t           pos_b_q;
  logic           vb_q;

  sample_t        sel;

  // First stage: compare every window element with every other one
  always_comb begin
    for (int i = 0; i < WSQ; i++) begin
      for (int j = 0; j < WSQ; j++) begin
        lt_d[i][j] = $signed(win_i[j]) < $signed(win_i[i]);
        eq_d[i][j] = win_i[j] == win_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q    <= lt_d;
    eq_q    <= eq_d;
    win_a_q <= win_i;
    pos_a_q <= pos_i;
  end

  // Second stage: an element is the median when the wanted rank falls
  // inside its run of equal values.
  always_comb begin
    logic [RANK_CNT_BITS-1:0] less;
    logic [RANK_CNT_BITS-1:0] same;
    for (int i = 0; i < WSQ; i++) begin
      less = '0;
      same = '0;
      for (int j = 0; j < WSQ; j++) begin
        less = less + RANK_CNT_BITS'(lt_q[i][j]);
        same = same + RANK_CNT_BITS'(eq_q[i][j] && !lt_q[i][j]);
      end
      hit_d[i] = (less <= RANK_CNT_BITS'(RANK)) && (RANK_CNT_BITS'(RANK) < less + same);
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    win_b_q <= win_a_q;
    pos_b_q <= pos_a_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  // Pick the lowest-numbered element that holds the median rank
  always_comb begin
    sel = win_b_q[0];
    for (int i = WSQ - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        sel = win_b_q[i];
      end
    end
  end

  assign out_valid_o        = vb_q;
  assign out_item_o.median  = sel;
  assign out_item_o.out_row = pos_b_q.out_row;
  assign out_item_o.out_col = pos_b_q.out_col;
  assign occupancy_o        = RS_OCC_BITS'(va_q) + RS_OCC_BITS'(vb_q);

endmodule

FILE: rtl/wmf_out_fifo.sv
module wmf_out_fifo import wmf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  out_item_t                push_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o,
  output logic [FIFO_CNT_BITS-1:0] count_o
);

  out_item_t                slots_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] count_q;
  logic                     pop;

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers wrap naturally; the sender never pushes into a full queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + FIFO_CNT_BITS'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - FIFO_CNT_BITS'(1);
      end
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_item_o  = slots_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

FILE: rtl/window_median_filter_2d_top.sv
// 3x3 streaming median filter over a raster image of signed samples.
// Samples enter in row-major order on the input valid/ready channel; a set
// frame_start flag makes that sample row 0, column 0. Each transaction on the
// output channel carries the median of a full window and the position of its
// centre; border positions give no transaction. image_cols and image_rows are
// written through the plain write port; the user must do so only while the
// block is idle, which it does not enforce. Out-of-range values are clamped.
// Throughput is one sample per cycle while input ready is high. The two
// previous lines sit in one synchronous memory, read at the column of the
// incoming sample and written back in the next cycle, with forwarding when
// the same column comes twice. Each result passes four registers: memory
// read, window update with the comparison matrix, rank count, result queue.
// Results wait in an eight-entry queue. When the receiver stalls, input ready
// stays high until queued plus in-flight results fill that queue. Reset
// clears the counters, the window and the queue, restores both image size
// registers to 1024 and empties the line store by a fill count, so no
// clearing pass is needed and samples are taken from the first cycle.
module window_median_filter_2d_top import wmf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o
);

  logic [COLS_REG_BITS-1:0] cols_q;
  logic [ROWS_REG_BITS-1:0] rows_q;
  logic [COLS_REG_BITS-1:0] cols_eff;
  logic [ROWS_REG_BITS-1:0] rows_eff;

  logic [COL_BITS-1:0] col_q, col_d, cc;
  logic [ROW_BITS-1:0] row_q, row_d, rc;
  logic                accept;
  logic                emit_d;

  logic                s1_act_q;
  logic                s1_emit_q;
  sample_t             s1_sample_q;
  logic [COL_BITS-1:0] s1_addr_q;
  pos_t                s1_pos_q;

  column_t             ls_rd;
  column_t             ls_wr;
  window_t             win_q, win_d;
  sample_t             column [WIN];

  logic                     rs_valid;
  out_item_t                rs_item;
  logic [RS_OCC_BITS-1:0]   rs_occ;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_REG_BITS'(1024);
      rows_q <= ROWS_REG_BITS'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_COLS: cols_q <= cfg_data_i[COLS_REG_BITS-1:0];
        REG_IMAGE_ROWS: rows_q <= cfg_data_i[ROWS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image width to what the line store can hold and zero sizes to one
  always_comb begin
    cols_eff = cols_q;
    if (cols_q == '0) begin
      cols_eff = COLS_REG_BITS'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = COLS_REG_BITS'(MAX_COLS);
    end
    rows_eff = (rows_q == '0) ? ROWS_REG_BITS'(1) : rows_q;
  end

  // Admit a sample only if its result is sure to find room in the queue
  assign in_ready_o = (32'(fifo_cnt) + 32'(s1_emit_q) + 32'(rs_occ)) < FIFO_DEPTH;
  assign accept     = in_valid_i && in_ready_o;

  // Position of the incoming sample and the next position
  always_comb begin
    cc     = in_item_i.frame_start ? '0 : col_q;
    rc     = in_item_i.frame_start ? '0 : row_q;
    emit_d = (32'(rc) >= WIN - 1) && (32'(cc) >= WIN - 1) &&
             (32'(rc) < 32'(rows_eff)) && (32'(cc) < 32'(cols_eff));
    if (32'(cc) + 32'd1 >= 32'(cols_eff)) begin
      col_d = '0;
      row_d = (32'(rc) + 32'd1 >= 32'(rows_eff)) ? '0 : rc + ROW_BITS'(1);
    end else begin
      col_d = cc + COL_BITS'(1);
      row_d = rc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_act_q  <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      s1_act_q  <= accept;
      s1_emit_q <= accept && emit_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q      <= in_item_i.sample;
      s1_addr_q        <= cc;
      s1_pos_q.out_row <= rc - ROW_BITS'(LAG);
      s1_pos_q.out_col <= cc - COL_BITS'(LAG);
    end
  end

  wmf_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (cc),
    .wr_en_i   (s1_act_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (ls_wr),
    .rd_data_o (ls_rd)
  );

  // Lines move down by one: the new sample enters the youngest line
  always_comb begin
    ls_wr[0] = s1_sample_q;
    for (int k = 1; k < LINES; k++) begin
      ls_wr[k] = ls_rd[k-1];
    end
  end

  // New window column, oldest line at the top
  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      column[r] = ls_rd[LINES-1-r];
    end
    column[WIN-1] = s1_sample_q;
  end

  // Shift the window one column left and insert the new column
  always_comb begin
    win_d = win_q;
    if (s1_act_q) begin
      for (int r = 0; r < WIN; r++) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win_d[r*WIN+i] = win_q[r*WIN+i+1];
        end
        win_d[r*WIN+WIN-1] = column[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  wmf_rank_select u_rank_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_emit_q),
    .win_i       (win_d),
    .pos_i       (s1_pos_q),
    .out_valid_o (rs_valid),
    .out_item_o  (rs_item),
    .occupancy_o (rs_occ)
  );

  wmf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rs_valid),
    .push_item_i (rs_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .count_o     (fifo_cnt)
  );

endmodule

FILE: tb/sv/window_median_filter_2d_top_tb.sv
`timescale 1ns / 100ps

module window_median_filter_2d_top_tb;
  import wmf_pkg::*;

  localparam int unsigned RAND_ITEMS  = 480;
  localparam int unsigned WIDE_RUN    = 40;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE_TAIL = 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 100;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = CFG_IDX_BITS'(3);

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item    = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  out_item_t                out_item;

  // Shared testbench state
  in_item_t    samples_waiting [$];
  out_item_t   medians_due [$];
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_seen   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  logic        calm         = 1'b0;

  // Predictor state: registers, line stores, window and raster position
  logic [COLS_REG_BITS-1:0] cols_reg = COLS_REG_BITS'(1024);
  logic [ROWS_REG_BITS-1:0] rows_reg = ROWS_REG_BITS'(1024);
  sample_t                  lines_m [LINES][MAX_COLS];
  sample_t                  win_m [WSQ];
  int unsigned              row_m;
  int unsigned              col_m;

  window_median_filter_2d_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter that ends a run which has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** window_median_filter_2d_top: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none in calm stretches.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Effective image width and height after clamping the registers.
  function automatic int unsigned active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    return 32'(rows_reg);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic clear_filter_state();
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < MAX_COLS; c++) lines_m[r][c] = '0;
    for (int i = 0; i < WSQ; i++) win_m[i] = '0;
    row_m = 0;
    col_m = 0;
  endtask

  // Advances the filter by one sample and queues the median it yields, if any.
  function automatic void filter_sample(input in_item_t it);
    int unsigned cols, rows, c, orow, ocol;
    sample_t     column [WIN];
    int          vals [WSQ];
    int          key, j;
    out_item_t   res;
    cols = active_cols();
    rows = active_rows();
    if (it.frame_start) begin
      row_m = 0;
      col_m = 0;
    end
    c = (col_m >= MAX_COLS) ? MAX_COLS - 1 : col_m;

    // Column of the window: oldest line first, the new sample last.
    for (int r = 0; r < LINES; r++) column[r] = lines_m[LINES-1-r][c];
    column[WIN-1] = it.sample;
    for (int r = LINES - 1; r > 0; r--) lines_m[r][c] = lines_m[r-1][c];
    lines_m[0][c] = it.sample;

    for (int r = 0; r < WIN; r++) begin
      for (int i = 0; i < WIN - 1; i++) win_m[r*WIN+i] = win_m[r*WIN+i+1];
      win_m[r*WIN+WIN-1] = column[r];
    end

    // A full window inside the current frame gives its median.
    if (row_m >= WIN - 1 && col_m >= WIN - 1 && row_m < rows && col_m < cols) begin
      for (int i = 0; i < WSQ; i++) vals[i] = int'(win_m[i]);
      for (int i = 1; i < WSQ; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      orow = row_m - (WIN - 1) + WIN / 2;
      ocol = col_m - (WIN - 1) + WIN / 2;
      res.median  = sample_t'(vals[RANK]);
      res.out_row = ROW_BITS'(orow);
      res.out_col = COL_BITS'(ocol);
      medians_due.push_back(res);
    end

    // Raster position of the next sample.
    if (col_m + 1 >= cols) begin
      col_m = 0;
      if (row_m + 1 >= rows) row_m = 0;
      else row_m++;
    end else begin
      col_m++;
    end
  endfunction

  task automatic check_median(input out_item_t got);
    out_item_t want;
    if (medians_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result row %0d col %0d median %0d",
                              got.out_row, got.out_col, $signed(got.median)));
    end else begin
      want = medians_due.pop_front();
      if (got.median !== want.median)
        flag_mismatch($sformatf("median %0d, expected %0d at row %0d col %0d",
                                $signed(got.median), $signed(want.median),
                                want.out_row, want.out_col));
      if (got.out_row !== want.out_row)
        flag_mismatch($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
      if (got.out_col !== want.out_col)
        flag_mismatch($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
    end
  endtask

  // Driver: offers queued samples with random gaps between transactions.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) filter_sample(in_item);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (samples_waiting.size() != 0) begin
          in_item  <= samples_waiting.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls the output at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      holds_seen <= 0;
    end else begin
      if (out_valid && out_ready) check_median(out_item);
      if (holds_seen != holds_asked) begin
        holds_seen <= holds_asked;
        stall_left <= LONG_HOLD;
        out_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  task automatic offer(input sample_t s, input logic fs);
    in_item_t it;
    it.sample      = s;
    it.frame_start = fs;
    samples_waiting.push_back(it);
  endtask

  function automatic sample_t rand_sample();
    if ($urandom_range(0, 9) < 7) return sample_t'($urandom);
    // A narrow range gives many equal values in a window.
    return sample_t'(int'($urandom_range(0, 4)) - 2);
  endfunction

  // Register write; the write enable stays high across back-to-back writes.
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_IMAGE_COLS: cols_reg = data[COLS_REG_BITS-1:0];
      REG_IMAGE_ROWS: rows_reg = data[ROWS_REG_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every sample is taken and every median has arrived, then lets
  // the pipeline empty of samples that give no result.
  task automatic settle();
    while (samples_waiting.size() != 0 || in_valid || medians_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  initial begin
    int unsigned k, n, nframes, rows_sent, eff_c, eff_r, rand_items, phase;
    logic [CFG_DATA_BITS-1:0] cols_v, rows_v;
    logic clean;
    clear_filter_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest image that gives a result; the spare index must be ignored.
    cfg_write(REG_IMAGE_COLS, 16'd3);
    cfg_write(REG_IMAGE_ROWS, 16'd3);
    cfg_write(REG_SPARE_LO, 16'h0001);
    cfg_close();
    // Extreme samples, frame start on the first one.
    offer(16'sh7FFF, 1'b1); offer(16'sh8000, 1'b0); offer(16'sh0000, 1'b0);
    offer(16'shFFFF, 1'b0); offer(16'sh0001, 1'b0); offer(16'sh7FFF, 1'b0);
    offer(16'sh8000, 1'b0); offer(16'sh8000, 1'b0); offer(16'sh7FFF, 1'b0);
    // Next frame begins by row wrap alone; equal values in the window.
    offer(16'sh0005, 1'b0); offer(16'sh0005, 1'b0); offer(16'shFFFD, 1'b0);
    offer(16'shFFFD, 1'b0); offer(16'sh0007, 1'b0); offer(16'sh0005, 1'b0);
    offer(16'sh0007, 1'b0); offer(16'sh0007, 1'b0); offer(16'shFFFD, 1'b0);
    // Frame start in the middle of a row.
    offer(16'sh0123, 1'b1); offer(16'sh4000, 1'b0); offer(16'sh8000, 1'b1);
    offer(16'sh7FFF, 1'b0); offer(16'shFFFF, 1'b0);
    settle();

    // Zero registers are taken as a one by one image: no result at all.
    cfg_write(REG_IMAGE_COLS, 16'd0);
    cfg_write(REG_IMAGE_ROWS, 16'd0);
    cfg_close();
    offer(16'sh1234, 1'b1); offer(16'shEDCB, 1'b0); offer(16'sh0F0F, 1'b1);
    settle();

    // Random phases, each under its own image size.
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      clean = (phase == 0);
      if (clean) begin
        cols_v = 16'd5;
        rows_v = 16'd6;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) cols_v = 16'($urandom_range(3, 10));
        else if (k < 80) cols_v = 16'($urandom_range(1, 2));
        else if (k < 85) cols_v = 16'd0;
        else if (k < 92) cols_v = 16'($urandom_range(MAX_COLS + 1, 2047));
        else cols_v = 16'($urandom_range(11, 40));
        // Bits above the register width must be dropped.
        if ($urandom_range(0, 4) == 0) cols_v = cols_v | (16'($urandom) & 16'hF800);
        k = $urandom_range(0, 99);
        if (k < 70) rows_v = 16'($urandom_range(3, 7));
        else if (k < 85) rows_v = 16'($urandom_range(0, 2));
        else if (k < 95) rows_v = 16'hFFFF;
        else rows_v = 16'($urandom_range(8, 20));
      end
      if (clean || $urandom_range(0, 3) != 0) begin
        cfg_write(REG_IMAGE_COLS, cols_v);
        cfg_write(REG_IMAGE_ROWS, rows_v);
      end else if ($urandom_range(0, 1) == 0) begin
        cfg_write(REG_IMAGE_COLS, cols_v);
      end else begin
        cfg_write(REG_IMAGE_ROWS, rows_v);
      end
      if ($urandom_range(0, 9) == 0)
        cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
      cfg_close();

      calm = !clean && ($urandom_range(0, 3) == 0);
      eff_c = active_cols();
      eff_r = active_rows();
      if (eff_c > 64) begin
        // Too wide to fill a window here: a short run of samples only.
        n = $urandom_range(10, 40);
        for (int i = 0; i < n; i++) offer(rand_sample(), i == 0);
        rand_items += n;
      end else begin
        nframes = clean ? 3 : $urandom_range(1, 3);
        for (int f = 0; f < nframes; f++) begin
          rows_sent = (eff_r > 8) ? $urandom_range(3, 6) : eff_r;
          n = eff_c * rows_sent;
          if (!clean && $urandom_range(0, 19) == 0) n = $urandom_range(1, n);
          for (int i = 0; i < n; i++) begin
            if (clean) offer(rand_sample(), i == 0);
            else if (i == 0) offer(rand_sample(), $urandom_range(0, 6) != 0);
            else offer(rand_sample(), $urandom_range(0, 49) == 0);
          end
          rand_items += n;
        end
      end
      // The first phase holds the output off long enough to fill the block.
      if (clean) holds_asked++;
      settle();
      phase++;
    end

    // Widest image: all-ones data clamps the width to the largest row, so a
    // short run stays within the first row and gives no result.
    calm = 1'b0;
    cfg_write(REG_IMAGE_COLS, 16'hFFFF);
    cfg_write(REG_IMAGE_ROWS, 16'hFFFF);
    cfg_close();
    for (int i = 0; i < WIDE_RUN; i++) offer(rand_sample(), i == 0);
    settle();

    if (medians_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", medians_due.size()));
    if (errors == 0) begin
      $display("** window_median_filter_2d_top: PASSED **");
    end else begin
      $display("** window_median_filter_2d_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wmf_pkg.sv
rtl/wmf_line_store.sv
rtl/wmf_rank_select.sv
rtl/wmf_out_fifo.sv
rtl/window_median_filter_2d_top.sv
tb/sv/window_median_filter_2d_top_tb.sv
